// ===== rtl/double_ended_queue_macros.svh =====
// Assertion macros shared by the double-ended queue RTL.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define DQ_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define DQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define DQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/dq_pkg.sv =====
// Shared constants and types of the double-ended queue.
package dq_pkg;

	localparam int DQ_DEPTH = 16;
	localparam int DATA_W   = 32;
	localparam int MODE_W   = 3;
	localparam int STAT_W   = 2;

	localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
	localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
	localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DUMP_FWD   = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DUMP_REV   = 3'd5;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

	typedef logic [2:0] cell_op_t;

	localparam cell_op_t CELL_HOLD        = 3'd0;
	localparam cell_op_t CELL_SHIFT_BACK  = 3'd1;
	localparam cell_op_t CELL_SHIFT_FRONT = 3'd2;
	localparam cell_op_t CELL_WRITE       = 3'd3;
	localparam cell_op_t CELL_ROT_FWD     = 3'd4;
	localparam cell_op_t CELL_ROT_REV     = 3'd5;

	typedef struct packed {
		cell_op_t op;
		logic     tail;  // cell holds the back element
		logic     slot;  // first free cell, target of a push at the back
	} cell_ctl_t;

endpackage

// ===== rtl/dq_cell.sv =====
// One storage cell of the element chain.
module dq_cell (
	input  logic                             clk,
	input  dq_pkg::cell_ctl_t                ctl,
	input  logic signed [dq_pkg::DATA_W-1:0] prev_data,
	input  logic signed [dq_pkg::DATA_W-1:0] next_data,
	input  logic signed [dq_pkg::DATA_W-1:0] head_data,
	input  logic signed [dq_pkg::DATA_W-1:0] in_value,
	output logic signed [dq_pkg::DATA_W-1:0] data
);

	logic signed [dq_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (ctl.op)
			dq_pkg::CELL_SHIFT_BACK:  data_q <= prev_data;
			dq_pkg::CELL_SHIFT_FRONT: data_q <= next_data;
			dq_pkg::CELL_WRITE: begin
				if (ctl.slot) begin
					data_q <= in_value;
				end
			end
			// The front element wraps around to the back of the run.
			dq_pkg::CELL_ROT_FWD:     data_q <= ctl.tail ? head_data : next_data;
			dq_pkg::CELL_ROT_REV:     data_q <= prev_data;
			default:                  data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

// ===== rtl/double_ended_queue.sv =====
// Top level of the double-ended queue: control and the chain of storage cells.
//
//   port group | dir | tdata            | tuser       | tlast
//   s_*        | in  | value (31:0)     | mode (2:0)  | -
//   m_*        | out | item_value (31:0)| status (1:0)| last_of_run
//
// A push or pop completes as it is accepted; a request is accepted every cycle
// while the output register is free and no dump runs. A dump holds s_tready low
// until its last element is loaded, as the chain rotates one position per result.
// Reset clears the element count and control; cell contents stay undefined.
// A stalled m_tready holds the result and blocks the next request.
module double_ended_queue #(
	parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic signed [dq_pkg::DATA_W-1:0]  s_tdata,  // value
	input  logic        [dq_pkg::MODE_W-1:0]  s_tuser,  // mode
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic signed [dq_pkg::DATA_W-1:0]  m_tdata,  // item_value
	output logic        [dq_pkg::STAT_W-1:0]  m_tuser,  // status
	output logic                              m_tlast   // last_of_run
);

	`include "double_ended_queue_macros.svh"

	localparam int CNT_W = $clog2(DEPTH + 1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DUMP = 1'b1;

	logic                              state_q, state_d;
	logic [CNT_W-1:0]                  count_q, count_d;
	logic [CNT_W-1:0]                  rem_q, rem_d;
	logic                              dir_q, dir_d;

	logic                              m_tvalid_q;
	logic signed [dq_pkg::DATA_W-1:0]  m_tdata_q;
	logic        [dq_pkg::STAT_W-1:0]  m_tuser_q;
	logic                              m_tlast_q;

	logic                              out_free, accept, full, empty;
	logic                              out_load, out_last;
	logic signed [dq_pkg::DATA_W-1:0]  out_value;
	logic        [dq_pkg::STAT_W-1:0]  out_status;
	dq_pkg::cell_op_t                  cell_op;

	logic signed [dq_pkg::DATA_W-1:0]  cell_data [DEPTH];
	logic signed [dq_pkg::DATA_W-1:0]  head_data, tail_data, first_prev;
	logic [DEPTH-1:0]                  tail_flag, slot_flag;

	assign head_data = cell_data[0];

	always_comb begin
		tail_data = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (tail_flag[i]) begin
				tail_data = tail_data | cell_data[i];
			end
		end
	end

	// The front cell takes the new value on a push, or the back element on a
	// reverse rotation.
	assign first_prev = (cell_op == dq_pkg::CELL_ROT_REV) ? tail_data : s_tdata;

	genvar g;
	generate
		for (g = 0; g < DEPTH; g++) begin : g_cell
			dq_pkg::cell_ctl_t                 ctl;
			logic signed [dq_pkg::DATA_W-1:0]  prev_data, next_data;

			assign tail_flag[g] = (count_q == CNT_W'(g + 1));
			assign slot_flag[g] = (count_q == CNT_W'(g));
			assign ctl.op       = cell_op;
			assign ctl.tail     = tail_flag[g];
			assign ctl.slot     = slot_flag[g];

			if (g == 0) begin : g_first
				assign prev_data = first_prev;
			end else begin : g_inner
				assign prev_data = cell_data[g-1];
			end

			if (g == DEPTH - 1) begin : g_last
				assign next_data = cell_data[g];
			end else begin : g_mid
				assign next_data = cell_data[g+1];
			end

			dq_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.prev_data (prev_data),
				.next_data (next_data),
				.head_data (head_data),
				.in_value  (s_tdata),
				.data      (cell_data[g])
			);
		end
	endgenerate

	always_comb begin
		out_free   = !m_tvalid_q || m_tready;
		s_tready   = (state_q == ST_IDLE) && out_free;
		accept     = s_tvalid && s_tready;
		full       = (count_q == CNT_W'(DEPTH));
		empty      = (count_q == '0);

		cell_op    = dq_pkg::CELL_HOLD;
		count_d    = count_q;
		state_d    = state_q;
		rem_d      = rem_q;
		dir_d      = dir_q;
		out_load   = 1'b0;
		out_value  = '0;
		out_status = dq_pkg::STAT_OK;
		out_last   = 1'b1;

		if (accept) begin
			case (s_tuser)
				dq_pkg::MODE_PUSH_FRONT, dq_pkg::MODE_PUSH_BACK: begin
					out_load = 1'b1;
					if (full) begin
						out_status = dq_pkg::STAT_FULL;
					end else begin
						cell_op = (s_tuser == dq_pkg::MODE_PUSH_FRONT) ?
						          dq_pkg::CELL_SHIFT_BACK : dq_pkg::CELL_WRITE;
						count_d = count_q + CNT_W'(1);
					end
				end
				dq_pkg::MODE_POP_FRONT, dq_pkg::MODE_POP_BACK: begin
					out_load = 1'b1;
					if (empty) begin
						out_status = dq_pkg::STAT_EMPTY;
					end else if (s_tuser == dq_pkg::MODE_POP_FRONT) begin
						out_value = head_data;
						cell_op   = dq_pkg::CELL_SHIFT_FRONT;
						count_d   = count_q - CNT_W'(1);
					end else begin
						out_value = tail_data;
						count_d   = count_q - CNT_W'(1);
					end
				end
				dq_pkg::MODE_DUMP_FWD, dq_pkg::MODE_DUMP_REV: begin
					if (empty) begin
						out_load   = 1'b1;
						out_status = dq_pkg::STAT_EMPTY;
					end else begin
						state_d = ST_DUMP;
						rem_d   = count_q;
						dir_d   = (s_tuser == dq_pkg::MODE_DUMP_REV);
					end
				end
				default: ;
			endcase
		end else if (state_q == ST_DUMP && out_free) begin
			// Emit one end of the run and rotate; after count steps the chain
			// is back in its original order.
			out_load  = 1'b1;
			out_value = dir_q ? tail_data : head_data;
			out_last  = (rem_q == CNT_W'(1));
			cell_op   = dir_q ? dq_pkg::CELL_ROT_REV : dq_pkg::CELL_ROT_FWD;
			rem_d     = rem_q - CNT_W'(1);
			if (out_last) begin
				state_d = ST_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			rem_q      <= '0;
			dir_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			rem_q   <= rem_d;
			dir_q   <= dir_d;
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= out_value;
			m_tuser_q <= out_status;
			m_tlast_q <= out_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	`DQ_ASSERT_ALWAYS(a_count_range, count_q <= CNT_W'(DEPTH), "element count exceeds depth")
	`DQ_ASSERT_IMP(a_dump_blocks, state_q == ST_DUMP, !s_tready, "request taken during a dump")
	`DQ_ASSERT_IMP(a_dump_rem, state_q == ST_DUMP, rem_q != '0 && rem_q <= count_q, "bad dump count")
	`DQ_ASSERT_NEXT(a_dump_count_hold, state_q == ST_DUMP, $stable(count_q), "count changed in dump")
	`DQ_ASSERT_IMP(a_error_last, m_tvalid_q && m_tuser_q != dq_pkg::STAT_OK, m_tlast_q, "error not last")

endmodule

// ===== tb/tb_double_ended_queue.sv =====
// Self-checking testbench of the double-ended queue: scripted and random requests.
module tb_double_ended_queue;
	timeunit 1ns;
	timeprecision 1ps;

	import dq_pkg::*;

	localparam int RING_DEPTH      = DQ_DEPTH;
	localparam int RANDOM_REQUESTS = 150;

	// Mode codes that the block has to ignore.
	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

	typedef struct packed {
		logic [DATA_W-1:0] value;
		logic [STAT_W-1:0] status;
		logic              last;
	} dq_result_t;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic [DATA_W-1:0] value;
		bit                typed;   // expected status given below, value 0, last set
		logic [STAT_W-1:0] status;
	} script_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [DATA_W-1:0] s_tdata = '0;   // value
	logic [MODE_W-1:0] s_tuser = '0;   // mode
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;        // item_value
	logic [STAT_W-1:0] m_tuser;        // status
	logic              m_tlast;        // last_of_run

	// Shadow copy of the ring, updated as each request is accepted.
	logic [DATA_W-1:0] ring_store [RING_DEPTH];
	int unsigned       ring_head = 0;
	int unsigned       ring_count = 0;
	dq_result_t        results_due [$];

	bit send_burst = 1'b0;
	bit drain_fast = 1'b0;
	int mismatch_count = 0;
	int requests_done = 0;
	int push_count = 0, pop_count = 0, dump_count = 0, ignored_count = 0;
	int checked_count = 0, full_seen = 0, empty_seen = 0;

	script_row_t opening_script [20] = '{
		'{MODE_POP_FRONT,  32'h0000_1234, 1'b1, STAT_EMPTY},
		'{MODE_POP_BACK,   32'hFFFF_FFFF, 1'b1, STAT_EMPTY},
		'{MODE_DUMP_FWD,   32'h0000_0000, 1'b1, STAT_EMPTY},
		'{MODE_DUMP_REV,   32'h8000_0000, 1'b1, STAT_EMPTY},
		'{MODE_UNUSED_LO,  32'h7FFF_FFFF, 1'b0, STAT_OK},
		'{MODE_UNUSED_HI,  32'hA5A5_A5A5, 1'b0, STAT_OK},
		'{MODE_PUSH_FRONT, 32'h7FFF_FFFF, 1'b1, STAT_OK},
		'{MODE_PUSH_BACK,  32'h8000_0000, 1'b1, STAT_OK},
		'{MODE_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, STAT_OK},
		'{MODE_PUSH_BACK,  32'h0000_0000, 1'b1, STAT_OK},
		'{MODE_DUMP_FWD,   32'h1111_1111, 1'b0, STAT_OK},
		'{MODE_DUMP_REV,   32'h2222_2222, 1'b0, STAT_OK},
		'{MODE_POP_FRONT,  32'h3333_3333, 1'b0, STAT_OK},
		'{MODE_POP_BACK,   32'h4444_4444, 1'b0, STAT_OK},
		'{MODE_POP_FRONT,  32'h5555_5555, 1'b0, STAT_OK},
		'{MODE_POP_BACK,   32'h6666_6666, 1'b0, STAT_OK},
		'{MODE_POP_BACK,   32'h7777_7777, 1'b1, STAT_EMPTY},
		'{MODE_PUSH_BACK,  32'h5555_5555, 1'b1, STAT_OK},
		'{MODE_DUMP_FWD,   32'hAAAA_AAAA, 1'b0, STAT_OK},
		'{MODE_POP_FRONT,  32'hCCCC_CCCC, 1'b0, STAT_OK}
	};

	double_ended_queue #(.DEPTH(RING_DEPTH)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one request to the shadow ring and lists the results it must cause.
	function automatic void deque_step(input logic [MODE_W-1:0] mode,
			input logic [DATA_W-1:0] value, ref dq_result_t produced [$]);
		int unsigned idx;
		int unsigned off;
		produced = {};
		case (mode)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (ring_count >= RING_DEPTH) begin
					produced.push_back('{'0, STAT_FULL, 1'b1});
				end else begin
					if (mode == MODE_PUSH_FRONT) begin
						ring_head = (ring_head + RING_DEPTH - 1) % RING_DEPTH;
						ring_store[ring_head] = value;
					end else begin
						ring_store[(ring_head + ring_count) % RING_DEPTH] = value;
					end
					ring_count++;
					produced.push_back('{'0, STAT_OK, 1'b1});
				end
			end
			MODE_POP_FRONT, MODE_POP_BACK: begin
				if (ring_count == 0) begin
					produced.push_back('{'0, STAT_EMPTY, 1'b1});
				end else if (mode == MODE_POP_FRONT) begin
					produced.push_back('{ring_store[ring_head], STAT_OK, 1'b1});
					ring_head = (ring_head + 1) % RING_DEPTH;
					ring_count--;
				end else begin
					off = (ring_head + ring_count - 1) % RING_DEPTH;
					produced.push_back('{ring_store[off], STAT_OK, 1'b1});
					ring_count--;
				end
			end
			MODE_DUMP_FWD, MODE_DUMP_REV: begin
				if (ring_count == 0) begin
					produced.push_back('{'0, STAT_EMPTY, 1'b1});
				end else begin
					for (idx = 0; idx < ring_count; idx++) begin
						off = (mode == MODE_DUMP_FWD) ? idx : ring_count - 1 - idx;
						produced.push_back('{ring_store[(ring_head + off) % RING_DEPTH],
							STAT_OK, idx + 1 == ring_count});
					end
				end
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [DATA_W-1:0] draw_value();
		case ($urandom_range(0, 9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
			default: return $urandom();
		endcase
	endfunction

	// Leaves tvalid high into the next request when no gap is drawn.
	task automatic issue_request(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] value,
			input bit typed = 1'b0, input logic [STAT_W-1:0] status = STAT_OK);
		int gap;
		dq_result_t produced [$];
		gap = send_burst ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		deque_step(mode, value, produced);
		if (typed)
			results_due.push_back('{'0, status, 1'b1});
		else
			foreach (produced[i]) results_due.push_back(produced[i]);
		case (mode)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: push_count++;
			MODE_POP_FRONT, MODE_POP_BACK:   pop_count++;
			MODE_DUMP_FWD, MODE_DUMP_REV:    dump_count++;
			default:                         ignored_count++;
		endcase
		if (produced.size() != 0)
			requests_done++;
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0) @(posedge clk);
	endtask

	// Result side: random stalls, then compare each result with the oldest one due.
	initial begin
		int stall;
		dq_result_t got;
		dq_result_t want;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0)
				drain_fast = !drain_fast;
			stall = drain_fast ? 0 : $urandom_range(0, 10);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = '{m_tdata, m_tuser, m_tlast};
			checked_count++;
			if (got.status == STAT_FULL)
				full_seen++;
			if (got.status == STAT_EMPTY)
				empty_seen++;
			if (results_due.size() == 0) begin
				mismatch_count++;
				$display("%0t: expected nothing, got value %h status %0d last %0b",
					$time, got.value, got.status, got.last);
			end else begin
				want = results_due.pop_front();
				if (got !== want) begin
					mismatch_count++;
					$display("%0t: expected value %h status %0d last %0b, got value %h status %0d last %0b",
						$time, want.value, want.status, want.last,
						got.value, got.status, got.last);
				end
			end
		end
	end

	initial begin
		int base;
		int pick;
		logic [MODE_W-1:0] mode;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_script[i])
			issue_request(opening_script[i].mode, opening_script[i].value,
				opening_script[i].typed, opening_script[i].status);
		hold_until_drained();

		base = requests_done;
		while (requests_done < base + RANDOM_REQUESTS) begin
			send_burst = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 5))
				0: begin
					// Fill to the top, and at times past it, so that pushes into a full ring get dropped.
					repeat (RING_DEPTH - ring_count + $urandom_range(0, 2))
						issue_request($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK,
							draw_value());
				end
				1: begin
					repeat (ring_count + $urandom_range(0, 2))
						issue_request($urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK,
							draw_value());
				end
				2, 3: begin
					repeat ($urandom_range(4, 12)) begin
						pick = $urandom_range(0, 19);
						if (pick < 8)
							mode = $urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK;
						else if (pick < 15)
							mode = $urandom_range(0, 1) ? MODE_POP_FRONT : MODE_POP_BACK;
						else if (pick < 19)
							mode = $urandom_range(0, 1) ? MODE_DUMP_FWD : MODE_DUMP_REV;
						else
							mode = $urandom_range(0, 1) ? MODE_UNUSED_LO : MODE_UNUSED_HI;
						issue_request(mode, draw_value());
					end
				end
				4: begin
					repeat ($urandom_range(0, 5))
						issue_request($urandom_range(0, 1) ? MODE_PUSH_FRONT : MODE_PUSH_BACK,
							draw_value());
					issue_request(MODE_DUMP_FWD, draw_value());
					issue_request(MODE_DUMP_REV, draw_value());
				end
				default: hold_until_drained();
			endcase
		end

		s_tvalid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (RING_DEPTH + 4) @(posedge clk);

		$display("Sent %0d pushes, %0d pops, %0d dumps and %0d ignored requests.",
			push_count, pop_count, dump_count, ignored_count);
		$display("Checked %0d results, %0d of them full drops and %0d empty reports.",
			checked_count, full_seen, empty_seen);
		if (mismatch_count == 0)
			$display("tb_double_ended_queue: done, clean");
		else
			$display("tb_double_ended_queue: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb_double_ended_queue: done, errors");
		$finish;
	end

endmodule
